// ===== rtl/sync_length_frame_parser_assert.svh =====
// Assertion macros shared by the frame parser modules.
`ifndef SYNC_LENGTH_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SLFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// ===== rtl/slfp_pkg.sv =====
// Shared types and constants of the sync/length frame parser.
`default_nettype none

package slfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned IDX_W  = 6;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'h55;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIM  = 2'd2;

  typedef enum logic [6:0] {
    ST_SYNC1 = 7'b0000001,
    ST_SYNC2 = 7'b0000010,
    ST_LEN   = 7'b0000100,
    ST_CMD   = 7'b0001000,
    ST_PAY   = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_DRAIN = 7'b1000000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic cap_len;
    logic cap_cmd;
    logic wr_pay;
    logic load_result;
    logic start_drain;
    logic drain_step;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic sync1_match;
    logic sync2_match;
    logic len_ok;
    logic len_zero;
    logic pay_done;
    logic check_ok;
    logic out_free;
    logic drain_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sync_length_frame_parser.sv =====
// Sync/length/command frame parser with XOR checksum, byte-serial input.
//
// Takes one received byte per accepted input beat and walks the frame layout
// first sync, second sync, length, command, payload, checksum. Payload bytes go
// into an on-chip store of MAX_LEN bytes; on a good checksum byte the input
// stalls while the store is read back, one result beat per cycle while the
// output does not stall. An empty frame or a checksum mismatch gives one result
// beat in the cycle after the checksum byte. A wrong second sync byte returns
// to hunting and a length above the smaller of length_limit and MAX_LEN drops
// the frame without any result. Configuration writes are taken at any time but
// belong between frames.
`default_nettype none

module sync_length_frame_parser
  import slfp_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] rx_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [BYTE_W-1:0]      command,
  output logic [LEN_W-1:0]       frame_length,
  output logic [IDX_W-1:0]       byte_index,
  output logic [BYTE_W-1:0]      payload_byte,
  output logic                   has_payload,
  output logic [BYTE_W-1:0]      received_check,
  output logic                   last
);

  dp_cmd_t    cmd;
  dp_status_t st;

  slfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  slfp_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .command        (command),
    .frame_length   (frame_length),
    .byte_index     (byte_index),
    .payload_byte   (payload_byte),
    .has_payload    (has_payload),
    .received_check (received_check),
    .last           (last)
  );

endmodule

`default_nettype wire

// ===== rtl/slfp_ctrl.sv =====
// Frame parser controller: phase state machine and input stall.
`default_nettype none

module slfp_ctrl
  import slfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t st,
  output dp_cmd_t         cmd
);

  `include "sync_length_frame_parser_assert.svh"

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    case (state)
      ST_CHECK: in_stall = !st.out_free;
      ST_DRAIN: in_stall = 1'b1;
      default:  in_stall = 1'b0;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_SYNC2: begin
        if (accept) state_next = st.sync2_match ? ST_LEN : ST_SYNC1;
      end
      ST_LEN: begin
        if (accept) begin
          if (st.len_ok) begin
            cmd.cap_len = 1'b1;
            state_next  = ST_CMD;
          end else begin
            state_next = ST_SYNC1;
          end
        end
      end
      ST_CMD: begin
        if (accept) begin
          cmd.cap_cmd = 1'b1;
          state_next  = st.len_zero ? ST_CHECK : ST_PAY;
        end
      end
      ST_PAY: begin
        if (accept) begin
          cmd.wr_pay = 1'b1;
          if (st.pay_done) state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (accept) begin
          // mismatch or empty frame: one result straight away
          if (!st.check_ok || st.len_zero) begin
            cmd.load_result = 1'b1;
            state_next      = ST_SYNC1;
          end else begin
            cmd.start_drain = 1'b1;
            state_next      = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (st.out_free) begin
          cmd.drain_step = 1'b1;
          if (st.drain_last) state_next = ST_SYNC1;
        end
      end
      default: begin
        if (accept) state_next = st.sync1_match ? ST_SYNC2 : ST_SYNC1;
        else        state_next = ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC1;
    end else begin
      state <= state_next;
    end
  end

  `SLFP_ASSERT_IMP(a_drain_blocks_input, state == ST_DRAIN, in_stall)
  `SLFP_ASSERT_IMP(a_check_waits_output, (state == ST_CHECK) && !st.out_free, in_stall)
  `SLFP_ASSERT_NXT(a_drain_ends,
    (state == ST_DRAIN) && st.out_free && st.drain_last, state == ST_SYNC1)

endmodule

`default_nettype wire

// ===== rtl/slfp_dp.sv =====
// Frame parser datapath: config registers, frame fields, payload store, result register.
`default_nettype none

module slfp_dp
  import slfp_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [BYTE_W-1:0] cfg_data,
  input  wire logic [BYTE_W-1:0] rx_byte,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             st,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [BYTE_W-1:0]      command,
  output logic [LEN_W-1:0]       frame_length,
  output logic [IDX_W-1:0]       byte_index,
  output logic [BYTE_W-1:0]      payload_byte,
  output logic                   has_payload,
  output logic [BYTE_W-1:0]      received_check,
  output logic                   last
);

  `include "sync_length_frame_parser_assert.svh"

  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_LEN);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_LEN);

  logic [BYTE_W-1:0] first_sync;
  logic [BYTE_W-1:0] second_sync;
  logic [LEN_W-1:0]  length_limit;

  logic [LEN_W-1:0]  held_length;
  logic [BYTE_W-1:0] held_command;
  logic [BYTE_W-1:0] running_check;
  logic [BYTE_W-1:0] rcv_check;
  logic [CNT_W-1:0]  pay_count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  ptr_next;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] mem [MAX_LEN];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync   <= FIRST_SYNC_RESET;
      second_sync  <= SECOND_SYNC_RESET;
      length_limit <= LENGTH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SYNC:  first_sync   <= cfg_data;
        REG_SECOND_SYNC: second_sync  <= cfg_data;
        REG_LENGTH_LIM:  length_limit <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit = ({1'b0, length_limit} < MAX_LEN_B) ? {1'b0, length_limit} : MAX_LEN_B;

  always_comb begin
    st.sync1_match = (rx_byte == first_sync);
    st.sync2_match = (rx_byte == second_sync);
    st.len_ok      = (rx_byte <= limit);
    st.len_zero    = (held_length == '0);
    st.pay_done    = ((BYTE_W'(pay_count) + 8'd1) >= {1'b0, held_length});
    st.check_ok    = (running_check == rx_byte);
    st.out_free    = !out_valid || !out_stall;
    st.drain_last  = ((BYTE_W'(ptr) + 8'd1) == {1'b0, held_length});
  end

  // frame fields
  always_ff @(posedge clk) begin
    if (rst) begin
      held_length   <= '0;
      held_command  <= '0;
      running_check <= '0;
      pay_count     <= '0;
    end else begin
      if (cmd.cap_len) begin
        held_length   <= rx_byte[LEN_W-1:0];
        running_check <= rx_byte;
      end
      if (cmd.cap_cmd) begin
        held_command  <= rx_byte;
        running_check <= running_check ^ rx_byte;
        pay_count     <= '0;
      end
      if (cmd.wr_pay) begin
        pay_count     <= pay_count + 1'b1;
        running_check <= running_check ^ rx_byte;
      end
    end
  end

  // drain pointer; read address runs one step ahead so rd_data matches ptr
  always_comb begin
    ptr_next = ptr;
    if (cmd.start_drain) begin
      ptr_next = '0;
    end else if (cmd.drain_step) begin
      ptr_next = st.drain_last ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pay) mem[pay_count[ADDR_W-1:0]] <= rx_byte;
    rd_data <= mem[ptr_next[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start_drain) rcv_check <= rx_byte;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result || cmd.drain_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status         <= !st.check_ok;
      command        <= held_command;
      frame_length   <= held_length;
      byte_index     <= '0;
      payload_byte   <= '0;
      has_payload    <= 1'b0;
      received_check <= rx_byte;
      last           <= 1'b1;
    end else if (cmd.drain_step) begin
      status         <= 1'b0;
      command        <= held_command;
      frame_length   <= held_length;
      byte_index     <= IDX_W'(ptr);
      payload_byte   <= rd_data;
      has_payload    <= 1'b1;
      received_check <= rcv_check;
      last           <= st.drain_last;
    end
  end

  `SLFP_ASSERT_IMP(a_store_in_range, cmd.wr_pay, pay_count < MAX_CNT)
  `SLFP_ASSERT_IMP(a_drain_in_range, cmd.drain_step, {1'b0, ptr} < (CNT_W+1)'(held_length))
  `SLFP_ASSERT_IMP(a_error_is_single, out_valid && status, !has_payload && last)

endmodule

`default_nettype wire
